// File: rtl/vnf_pkg.sv
// ----------------------------------------------------------------------------
// vnf_pkg: shared definitions for the fractal value noise block
// Hash constants, fixed-point widths, register codes and the divider table.
// ----------------------------------------------------------------------------
package vnf_pkg;

  localparam int MAX_OCTAVES = 8;
  localparam int COORD_W     = 16;
  localparam int FRAC_W      = 24;
  localparam int CELL_W      = 32;
  localparam int TOTAL_W     = FRAC_W + MAX_OCTAVES;
  localparam int OCT_CNT_W   = 4;
  localparam int CFG_IDX_W   = 8;
  localparam int CFG_DATA_W  = 64;
  localparam int SALT_STEP   = 101;

  localparam logic [63:0] K_X  = 64'h9E3779B97F4A7C15;
  localparam logic [63:0] K_Z  = 64'hC2B2AE3D27D4EB4F;
  localparam logic [63:0] K_S  = 64'h165667B19E3779F9;
  localparam logic [63:0] K_M1 = 64'hBF58476D1CE4E5B9;
  localparam logic [63:0] K_M2 = 64'h94D049BB133111EB;

  localparam logic [24:0] ONE_Q24 = 25'h1000000;

  localparam logic [63:0] SEED_RST     = 64'd0;
  localparam logic [31:0] BASE_FREQ_RST = 32'd1048576;
  localparam logic [3:0]  OCT_CNT_RST  = 4'd1;
  localparam logic [31:0] SALT_RST     = 32'd1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SEED      = 8'd0,
    CFG_BASE_FREQ = 8'd1,
    CFG_OCTAVES   = 8'd2,
    CFG_SALT      = 8'd3
  } cfg_reg_t;

  // floor(2^32 / (2^n - 1)) for n = 1..MAX_OCTAVES; the single-octave entry is
  // unused because that case divides by one.
  localparam logic [31:0] RECIP_TBL [MAX_OCTAVES] = '{
    32'd0, 32'd1431655765, 32'd613566756, 32'd286331153,
    32'd138547332, 32'd68174084, 32'd33818640, 32'd16843009
  };

  // Octave count clamped into 1..MAX_OCTAVES.
  function automatic logic [OCT_CNT_W-1:0] eff_octaves(input logic [OCT_CNT_W-1:0] cnt);
    logic [OCT_CNT_W-1:0] n;
    n = cnt;
    if (n == '0) n = OCT_CNT_W'(1);
    if (n > OCT_CNT_W'(MAX_OCTAVES)) n = OCT_CNT_W'(MAX_OCTAVES);
    return n;
  endfunction

endpackage

// File: rtl/vnf_in_if.sv
// ----------------------------------------------------------------------------
// vnf_in_if: sample point channel
// Carries one sample point per word with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface vnf_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] x_coord;
  logic signed [15:0] z_coord;

  modport source (output valid, output x_coord, output z_coord, input ready);
  modport sink   (input valid, input x_coord, input z_coord, output ready);
endinterface

// File: rtl/vnf_out_if.sv
// ----------------------------------------------------------------------------
// vnf_out_if: noise result channel
// Carries one Q0.24 noise value per word with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface vnf_out_if;
  logic        valid;
  logic        ready;
  logic [23:0] noise_value;

  modport source (output valid, output noise_value, input ready);
  modport sink   (input valid, input noise_value, output ready);
endinterface

// File: rtl/vnf_mul64.sv
// ----------------------------------------------------------------------------
// vnf_mul64: two-stage low-half 64x64 multiplier
// Three 32x32 partial products are registered, then summed and registered.
// ----------------------------------------------------------------------------
module vnf_mul64 (
  input  logic        clk,
  input  logic        en,
  input  logic [63:0] a,
  input  logic [63:0] b,
  output logic [63:0] p
);

  logic [63:0] ll_r;
  logic [31:0] lh_r;
  logic [31:0] hl_r;
  logic [63:0] p_r;
  logic [63:0] ll_nxt;
  logic [63:0] lh_nxt;
  logic [63:0] hl_nxt;

  always_comb begin
    ll_nxt = a[31:0] * b[31:0];
    lh_nxt = a[31:0] * b[63:32];
    hl_nxt = a[63:32] * b[31:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ll_r <= ll_nxt;
      lh_r <= lh_nxt[31:0];
      hl_r <= hl_nxt[31:0];
      p_r  <= ll_r + {lh_r + hl_r, 32'd0};
    end
  end

  assign p = p_r;

endmodule

// File: rtl/vnf_octave.sv
// ----------------------------------------------------------------------------
// vnf_octave: one octave of value noise
// Hashes the four cell corners and blends them with smoothstep weights.
// Fourteen register stages from cell inputs to the octave value.
// ----------------------------------------------------------------------------
module vnf_octave (
  input  logic        clk,
  input  logic        en,
  input  logic [63:0] seed,
  input  logic [31:0] salt_i,
  input  logic [31:0] cell_x,
  input  logic [31:0] cell_z,
  input  logic [23:0] frac_x,
  input  logic [23:0] frac_z,
  output logic [23:0] value
);
  import vnf_pkg::*;

  localparam int SX_DLY = 7;
  localparam int SZ_DLY = 9;

  // Corner order: 0 = (x0,z0), 1 = (x1,z0), 2 = (x0,z1), 3 = (x1,z1).
  logic [32:0] ax0_r, ax1_r, az0_r, az1_r, sp_r;
  logic [23:0] tx_r, tz_r, tx2_r, tz2_r, txd_r, tzd_r, sx_r, sz_r;
  logic [63:0] mx0, mx1, mz0, mz1, ms;
  logic [63:0] h1_r [4];
  logic [63:0] m1   [4];
  logic [63:0] h2_r [4];
  logic [63:0] m2   [4];
  logic [23:0] cv_r [4];
  logic [23:0] sx_pipe_r [SX_DLY];
  logic [23:0] sz_pipe_r [SZ_DLY];
  logic [48:0] pa_r, pb_r, pc_r, pd_r;
  logic [23:0] ab_r, cd_r;
  logic [48:0] pab_r, pcd_r;
  logic [23:0] v_r;
  logic [63:0] h1_nxt [4];
  logic [63:0] hx     [4];
  logic [47:0] sqx, sqz;
  logic [49:0] ex, ez;
  logic [48:0] sum_ab, sum_cd, sum_v;

  vnf_mul64 u_mx0 (.clk, .en, .a(K_X), .b({31'd0, ax0_r}), .p(mx0));
  vnf_mul64 u_mx1 (.clk, .en, .a(K_X), .b({31'd0, ax1_r}), .p(mx1));
  vnf_mul64 u_mz0 (.clk, .en, .a(K_Z), .b({31'd0, az0_r}), .p(mz0));
  vnf_mul64 u_mz1 (.clk, .en, .a(K_Z), .b({31'd0, az1_r}), .p(mz1));
  vnf_mul64 u_ms  (.clk, .en, .a(K_S), .b({31'd0, sp_r}),  .p(ms));

  always_comb begin
    hx[0] = seed ^ mx0 ^ mz0 ^ ms;
    hx[1] = seed ^ mx1 ^ mz0 ^ ms;
    hx[2] = seed ^ mx0 ^ mz1 ^ ms;
    hx[3] = seed ^ mx1 ^ mz1 ^ ms;
    for (int k = 0; k < 4; k++) begin
      h1_nxt[k] = hx[k] ^ (hx[k] >> 30);
    end
    sqx = tx_r * tx_r;
    sqz = tz_r * tz_r;
    ex  = tx2_r * (26'h3000000 - {1'b0, txd_r, 1'b0});
    ez  = tz2_r * (26'h3000000 - {1'b0, tzd_r, 1'b0});
    sum_ab = pa_r + pb_r;
    sum_cd = pc_r + pd_r;
    sum_v  = pab_r + pcd_r;
  end

  genvar g;
  generate
    for (g = 0; g < 4; g++) begin : g_corner
      vnf_mul64 u_m1 (.clk, .en, .a(h1_r[g]), .b(K_M1), .p(m1[g]));
      vnf_mul64 u_m2 (.clk, .en, .a(h2_r[g]), .b(K_M2), .p(m2[g]));
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (en) begin
      // Stage 1: corner coordinates plus one, as in the hash.
      ax0_r <= {1'b0, cell_x} + 33'd1;
      ax1_r <= {1'b0, cell_x + 32'd1} + 33'd1;
      az0_r <= {1'b0, cell_z} + 33'd1;
      az1_r <= {1'b0, cell_z + 32'd1} + 33'd1;
      sp_r  <= {1'b0, salt_i} + 33'd1;
      tx_r  <= frac_x;
      tz_r  <= frac_z;
      // Stages 2 and 3: smoothstep, alongside the first multiplies.
      tx2_r <= sqx[47:24];
      tz2_r <= sqz[47:24];
      txd_r <= tx_r;
      tzd_r <= tz_r;
      sx_r  <= ex[47:24];
      sz_r  <= ez[47:24];
      // Stages 4 to 10: combine, xor-shifts and corner value. The final xor-shift
      // by 31 does not reach the top 24 bits, so the corner value is the top of m2.
      for (int k = 0; k < 4; k++) begin
        h1_r[k] <= h1_nxt[k];
        h2_r[k] <= m1[k] ^ (m1[k] >> 27);
        cv_r[k] <= m2[k][63:40];
      end
      sx_pipe_r[0] <= sx_r;
      for (int k = 1; k < SX_DLY; k++) sx_pipe_r[k] <= sx_pipe_r[k-1];
      sz_pipe_r[0] <= sz_r;
      for (int k = 1; k < SZ_DLY; k++) sz_pipe_r[k] <= sz_pipe_r[k-1];
      // Stages 11 and 12: blend along x for both rows.
      pa_r  <= cv_r[0] * (ONE_Q24 - {1'b0, sx_pipe_r[SX_DLY-1]});
      pb_r  <= cv_r[1] * sx_pipe_r[SX_DLY-1];
      pc_r  <= cv_r[2] * (ONE_Q24 - {1'b0, sx_pipe_r[SX_DLY-1]});
      pd_r  <= cv_r[3] * sx_pipe_r[SX_DLY-1];
      ab_r  <= sum_ab[47:24];
      cd_r  <= sum_cd[47:24];
      // Stages 13 and 14: blend along z.
      pab_r <= ab_r * (ONE_Q24 - {1'b0, sz_pipe_r[SZ_DLY-1]});
      pcd_r <= cd_r * sz_pipe_r[SZ_DLY-1];
      v_r   <= sum_v[47:24];
    end
  end

  assign value = v_r;

endmodule

// File: rtl/value_noise_fbm_2d.sv
// ----------------------------------------------------------------------------
// value_noise_fbm_2d: two-dimensional fractal value noise, Q0.24 result
// Throughput is one word per cycle; the whole pipeline holds only while a
// result waits at the output and the consumer is not ready.
// Reset (synchronous, rst_n low) clears all valid bits and loads the
// register defaults: seed 0, base frequency 1/16, one octave, salt 1.
// ----------------------------------------------------------------------------
module value_noise_fbm_2d (
  input  logic                           clk,
  input  logic                           rst_n,
  vnf_in_if.sink                         in_chan,
  vnf_out_if.source                      out_chan,
  input  logic                           cfg_we,
  input  logic [vnf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [vnf_pkg::CFG_DATA_W-1:0] cfg_data
);
  import vnf_pkg::*;

  // Input register, coordinate multiply, 14 octave stages, a three-level
  // adder tree, and three stages of division by the weight sum.
  localparam int PIPE_DEPTH = 22;
  localparam int OCT_IDX_W  = $clog2(MAX_OCTAVES);

  logic [63:0]          seed_r;
  logic [31:0]          base_freq_r;
  logic [OCT_CNT_W-1:0] oct_cnt_r;
  logic [31:0]          salt_r;

  logic [PIPE_DEPTH-1:0] vld_r;
  logic                  adv;

  logic signed [15:0] x_r, z_r;
  logic [47:0]        px_r, pz_r;
  logic signed [48:0] px_full, pz_full;

  logic [23:0]          oct_val [MAX_OCTAVES];
  logic [TOTAL_W-1:0]   term    [MAX_OCTAVES];
  logic [TOTAL_W-1:0]   sa_r    [4];
  logic [TOTAL_W-1:0]   sb_r    [2];
  logic [TOTAL_W-1:0]   total_r;
  logic [TOTAL_W-1:0]   total_d_r;
  logic [63:0]          prod_r;
  logic [TOTAL_W-1:0]   total_e_r;
  logic [23:0]          qe_r;
  logic [31:0]          qd_r;
  logic [23:0]          noise_r;

  logic [OCT_CNT_W-1:0] n_eff;
  logic [OCT_IDX_W-1:0] recip_idx;
  logic [7:0]           divisor;
  logic [8:0]           div_wide;
  logic [23:0]          qe_nxt;
  logic [TOTAL_W-1:0]   rem;

  // The pipeline moves unless a finished word is blocked at the output.
  assign adv           = !vld_r[PIPE_DEPTH-1] || out_chan.ready;
  assign in_chan.ready = adv;

  // Configuration registers; the user must write them only while nothing is in
  // flight (the block does not enforce it), so the pipeline reads them directly at every stage.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_r      <= SEED_RST;
      base_freq_r <= BASE_FREQ_RST;
      oct_cnt_r   <= OCT_CNT_RST;
      salt_r      <= SALT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SEED:      seed_r      <= cfg_data;
        CFG_BASE_FREQ: base_freq_r <= cfg_data[31:0];
        CFG_OCTAVES:   oct_cnt_r   <= cfg_data[OCT_CNT_W-1:0];
        CFG_SALT:      salt_r      <= cfg_data[31:0];
        default: ;
      endcase
    end
  end

  // Valid bits travel alongside the data and advance with it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[PIPE_DEPTH-2:0], in_chan.valid};
    end
  end

  // Scaled positions are exact Q.24 products of the coordinate and the base
  // frequency; the octave shift is applied per lane below.
  assign px_full = x_r * $signed({1'b0, base_freq_r});
  assign pz_full = z_r * $signed({1'b0, base_freq_r});

  always_ff @(posedge clk) begin
    if (adv) begin
      x_r  <= in_chan.x_coord;
      z_r  <= in_chan.z_coord;
      px_r <= px_full[47:0];
      pz_r <= pz_full[47:0];
    end
  end

  // One octave lane per possible layer. Each lane takes its cell from bits
  // 24 and up of the shifted position and its fraction from the low bits.
  genvar g;
  generate
    for (g = 0; g < MAX_OCTAVES; g++) begin : g_oct
      logic [55:0] sx_pos, sz_pos;
      assign sx_pos = {{8{px_r[47]}}, px_r} << g;
      assign sz_pos = {{8{pz_r[47]}}, pz_r} << g;

      vnf_octave u_oct (
        .clk    (clk),
        .en     (adv),
        .seed   (seed_r),
        .salt_i (salt_r + 32'(SALT_STEP * g)),
        .cell_x (sx_pos[55:24]),
        .cell_z (sz_pos[55:24]),
        .frac_x (sx_pos[23:0]),
        .frac_z (sz_pos[23:0]),
        .value  (oct_val[g])
      );
    end
  endgenerate

  // Octave i is weighted by 2^(n-1-i); lanes beyond the count contribute
  // nothing. The weight sum is then 2^n - 1.
  always_comb begin
    n_eff     = eff_octaves(oct_cnt_r);
    recip_idx = OCT_IDX_W'(n_eff - OCT_CNT_W'(1));
    div_wide  = (9'd1 << n_eff) - 9'd1;
    divisor   = div_wide[7:0];
    for (int i = 0; i < MAX_OCTAVES; i++) begin
      if (OCT_CNT_W'(i) < n_eff) begin
        term[i] = TOTAL_W'(oct_val[i]) << (n_eff - OCT_CNT_W'(1) - OCT_CNT_W'(i));
      end else begin
        term[i] = '0;
      end
    end
    // The reciprocal estimate is at most one low; a single octave needs none.
    if (n_eff == OCT_CNT_W'(1)) begin
      qe_nxt = total_d_r[23:0];
    end else begin
      qe_nxt = prod_r[55:32];
    end
    rem = total_e_r - qd_r;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 4; k++) sa_r[k] <= term[2*k] + term[2*k+1];
      for (int k = 0; k < 2; k++) sb_r[k] <= sa_r[2*k] + sa_r[2*k+1];
      total_r   <= sb_r[0] + sb_r[1];
      // Divide by the weight sum: reciprocal multiply, then one correction.
      prod_r    <= total_r * RECIP_TBL[recip_idx];
      total_d_r <= total_r;
      qe_r      <= qe_nxt;
      qd_r      <= qe_nxt * divisor;
      total_e_r <= total_d_r;
      if (rem >= TOTAL_W'(divisor)) begin
        noise_r <= qe_r + 24'd1;
      end else begin
        noise_r <= qe_r;
      end
    end
  end

  assign out_chan.valid       = vld_r[PIPE_DEPTH-1];
  assign out_chan.noise_value = noise_r;

endmodule

// File: tb/sv/vnf_scoreboard.sv
// ----------------------------------------------------------------------------
// vnf_scoreboard: expected noise values for the fractal value noise block
// Computes the noise value of each accepted sample point from a private copy
// of the registers and compares result words against them in order.
// ----------------------------------------------------------------------------
class vnf_scoreboard;

  logic [63:0] seed;
  logic [31:0] base_freq;
  logic [3:0]  octaves;
  logic [31:0] salt;

  logic [23:0] pending_noise[$];
  int          mismatch_count;
  int          orphan_count;

  function new();
    seed           = vnf_pkg::SEED_RST;
    base_freq      = vnf_pkg::BASE_FREQ_RST;
    octaves        = vnf_pkg::OCT_CNT_RST;
    salt           = vnf_pkg::SALT_RST;
    mismatch_count = 0;
    orphan_count   = 0;
  endfunction

  function void write_reg(vnf_pkg::cfg_reg_t idx, logic [63:0] value);
    case (idx)
      vnf_pkg::CFG_SEED:      seed = value;
      vnf_pkg::CFG_BASE_FREQ: base_freq = value[31:0];
      vnf_pkg::CFG_OCTAVES:   octaves = value[3:0];
      vnf_pkg::CFG_SALT:      salt = value[31:0];
      default: ;
    endcase
  endfunction

  function logic [23:0] lattice_value(logic [31:0] cx, logic [31:0] cz, logic [31:0] s);
    logic [63:0] h;
    h = seed;
    h ^= vnf_pkg::K_X * ({32'd0, cx} + 64'd1);
    h ^= vnf_pkg::K_Z * ({32'd0, cz} + 64'd1);
    h ^= vnf_pkg::K_S * ({32'd0, s} + 64'd1);
    h ^= h >> 30;
    h *= vnf_pkg::K_M1;
    h ^= h >> 27;
    h *= vnf_pkg::K_M2;
    h ^= h >> 31;
    return h[63:40];
  endfunction

  function logic [63:0] smoothstep(logic [63:0] t);
    logic [63:0] t2;
    t2 = (t * t) >> 24;
    return (t2 * (64'd3 * 64'h1000000 - 64'd2 * t)) >> 24;
  endfunction

  function logic [63:0] lerp(logic [63:0] a, logic [63:0] b, logic [63:0] s);
    return (a * (64'h1000000 - s) + b * s) >> 24;
  endfunction

  function logic [23:0] noise_at(logic signed [15:0] x, logic signed [15:0] z);
    logic [63:0] xs, zs, px, pz, tx, tz, ab, cd, total;
    logic [31:0] x0, z0, s;
    int n;
    xs = {{48{x[15]}}, x};
    zs = {{48{z[15]}}, z};
    n = octaves;
    if (n < 1) n = 1;
    if (n > vnf_pkg::MAX_OCTAVES) n = vnf_pkg::MAX_OCTAVES;
    total = 0;
    for (int i = 0; i < n; i++) begin
      s  = salt + 32'(vnf_pkg::SALT_STEP * i);
      px = (xs * {32'd0, base_freq}) << i;
      pz = (zs * {32'd0, base_freq}) << i;
      x0 = px[55:24];
      z0 = pz[55:24];
      tx = smoothstep({40'd0, px[23:0]});
      tz = smoothstep({40'd0, pz[23:0]});
      ab = lerp(lattice_value(x0, z0, s), lattice_value(x0 + 1, z0, s), tx);
      cd = lerp(lattice_value(x0, z0 + 1, s), lattice_value(x0 + 1, z0 + 1, s), tx);
      total += lerp(ab, cd, tz) << (n - 1 - i);
    end
    total = total / ((64'd1 << n) - 1);
    return total[23:0];
  endfunction

  function void note_point(logic signed [15:0] x, logic signed [15:0] z);
    pending_noise.insert(pending_noise.size(), noise_at(x, z));
  endfunction

  function void check_noise(logic [23:0] got);
    logic [23:0] want;
    if (pending_noise.size() == 0) begin
      orphan_count++;
      if (orphan_count + mismatch_count <= 10)
        $display("unexpected result word: noise_value %h", got);
      return;
    end
    want = pending_noise.pop_front();
    if (got !== want) begin
      mismatch_count++;
      if (orphan_count + mismatch_count <= 10)
        $display("noise_value mismatch: expected %h, got %h", want, got);
    end
  endfunction

  function bit failed();
    return mismatch_count != 0 || orphan_count != 0 || pending_noise.size() != 0;
  endfunction
endclass

// File: tb/sv/value_noise_fbm_2d_tb.sv
// ----------------------------------------------------------------------------
// value_noise_fbm_2d_tb: self-checking bench for the fractal value noise block
// Drives sample points under several register settings with random idling and
// one long output stall, and checks every noise word against a scoreboard.
// ----------------------------------------------------------------------------
module value_noise_fbm_2d_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import vnf_pkg::*;

  localparam int LATENCY     = 22;
  localparam int CYCLE_LIMIT = 400000;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [7:0]  cfg_index;
  logic [63:0] cfg_data;

  vnf_in_if  in_chan ();
  vnf_out_if out_chan ();

  value_noise_fbm_2d i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_chan.sink),
    .out_chan  (out_chan.source),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  vnf_scoreboard noise_board;

  // Stall control: idle_enable turns on random stalls on both sides, and
  // hold_cycles asks the consumer for one long stall.
  bit idle_enable;
  int hold_cycles;
  int cycle_count;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog: a hung handshake ends the run as a failure.
  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  // Every word on the result channel is checked at the edge that accepts it.
  always @(posedge clk) begin
    if (rst_n && out_chan.valid && out_chan.ready)
      noise_board.check_noise(out_chan.noise_value);
  end

  // Consumer: ready toggles in bursts, with an optional long hold-off that is
  // counted in cycles here so that the producer keeps offering words.
  initial begin
    int burst;
    out_chan.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_cycles > 0) begin
        burst = hold_cycles;
        hold_cycles = 0;
        out_chan.ready <= 1'b0;
        repeat (burst) @(posedge clk);
      end else if (idle_enable && $urandom_range(0, 3) == 0) begin
        out_chan.ready <= 1'b0;
        repeat ($urandom_range(1, 4)) @(posedge clk);
      end else begin
        out_chan.ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // Offers one sample point and waits for its acceptance. Random gaps come
  // before the word, never while a held valid waits for acceptance.
  task automatic send_point(logic signed [15:0] x, logic signed [15:0] z);
    if (idle_enable && $urandom_range(0, 4) == 0) begin
      in_chan.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_chan.valid   <= 1'b1;
    in_chan.x_coord <= x;
    in_chan.z_coord <= z;
    do @(posedge clk); while (!in_chan.ready);
    noise_board.note_point(x, z);
  endtask

  task automatic drain();
    in_chan.valid <= 1'b0;
    while (noise_board.pending_noise.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  // Registers change only while the pipeline is empty. The enable drops
  // after each write so that writes can follow each other.
  task automatic write_reg(cfg_reg_t idx, logic [63:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    noise_board.write_reg(idx, value);
    @(posedge clk);
  endtask

  task automatic send_random(int count);
    logic signed [15:0] x, z;
    for (int k = 0; k < count; k++) begin
      case ($urandom_range(0, 5))
        0: begin
          x = 16'($urandom_range(0, 65535));
          z = 16'($urandom_range(0, 15)) - 16'sd8;
        end
        1: begin
          x = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
          z = 16'($urandom_range(0, 65535));
        end
        default: begin
          x = 16'($urandom_range(0, 65535));
          z = 16'($urandom_range(0, 65535));
        end
      endcase
      send_point(x, z);
    end
  endtask

  task automatic send_edges();
    logic signed [15:0] pts[10] = '{16'sh0000, 16'sh7fff, 16'sh8000, 16'shffff,
                                    16'sh0001, 16'sh5555, 16'shaaaa, 16'sh0010,
                                    16'shfff0, 16'sh1234};
    for (int k = 0; k < 10; k++)
      send_point(pts[k], pts[9 - k]);
  endtask

  // Random register setting: extremes are drawn often.
  task automatic random_setting();
    logic [31:0] f;
    case ($urandom_range(0, 3))
      0: f = 32'hffffffff;
      1: f = 32'd0;
      default: f = $urandom();
    endcase
    write_reg(CFG_SEED, {$urandom(), $urandom()});
    write_reg(CFG_BASE_FREQ, 64'(f));
    write_reg(CFG_OCTAVES, 64'($urandom_range(0, 15)));
    write_reg(CFG_SALT, $urandom_range(0, 1) ? 64'hffffffff : 64'($urandom()));
  endtask

  initial begin
    noise_board = new();
    idle_enable = 1'b0;
    hold_cycles = 0;
    rst_n           <= 1'b0;
    cfg_we          <= 1'b0;
    cfg_index       <= '0;
    cfg_data        <= '0;
    in_chan.valid   <= 1'b0;
    in_chan.x_coord <= '0;
    in_chan.z_coord <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part: reset defaults first, then the octave count at zero,
    // at the limit and saturated above it, with extreme registers.
    send_edges();
    drain();
    write_reg(CFG_OCTAVES, 64'd0);
    write_reg(CFG_SEED, 64'hffffffffffffffff);
    write_reg(CFG_SALT, 64'hffffffff);
    write_reg(CFG_BASE_FREQ, 64'hffffffff);
    send_point(16'sh7fff, 16'sh8000);
    send_point(16'sh8000, 16'sh7fff);
    drain();
    write_reg(CFG_OCTAVES, 64'd8);
    send_point(16'sh7fff, 16'sh7fff);
    send_point(16'sh8000, 16'sh8000);
    drain();
    write_reg(CFG_OCTAVES, 64'd15);
    write_reg(CFG_BASE_FREQ, 64'd0);
    send_point(16'sh1234, 16'shedcb);
    send_point(16'sh0000, 16'sh0000);
    drain();

    // Random phases with idling on both sides.
    idle_enable = 1'b1;
    for (int ph = 0; ph < 8; ph++) begin
      random_setting();
      if (ph == 2) hold_cycles = 200;
      send_random(140);
      drain();
    end

    // Last stretch runs at full rate with no idling.
    idle_enable = 1'b0;
    random_setting();
    send_random(200);
    drain();

    if (noise_board.failed()) begin
      $display("FAIL");
    end else begin
      $display("PASS");
    end
    $finish;
  end
endmodule

// File: files.f
rtl/vnf_pkg.sv
rtl/vnf_in_if.sv
rtl/vnf_out_if.sv
rtl/vnf_mul64.sv
rtl/vnf_octave.sv
rtl/value_noise_fbm_2d.sv
tb/sv/vnf_scoreboard.sv
tb/sv/value_noise_fbm_2d_tb.sv
